// ===== hw/rtl/rti_pkg.sv =====
// Shared types and constants for the ray/triangle intersector.
// Holds the request/response payload structs and the configuration register map.
package rti_pkg;

    localparam int COORD_WIDTH = 20;
    localparam int VERTEX_W    = 60;
    localparam int TEXC_W      = 40;
    localparam int MIN_DIST_W  = 20;
    localparam int CFG_DATA_W  = 60;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_ONE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_TWO   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_THREE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_TEXC_ONE     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_TEXC_TWO     = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_TEXC_THREE   = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST     = CFG_IDX_W'(6);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] origin_x;
        logic signed [COORD_WIDTH-1:0] origin_y;
        logic signed [COORD_WIDTH-1:0] origin_z;
        logic signed [COORD_WIDTH-1:0] dir_x;
        logic signed [COORD_WIDTH-1:0] dir_y;
        logic signed [COORD_WIDTH-1:0] dir_z;
    } t_ray_req;

    typedef struct packed {
        logic                          hit;
        logic        [COORD_WIDTH-1:0] distance;
        logic signed [COORD_WIDTH-1:0] tex_u;
        logic signed [COORD_WIDTH-1:0] tex_v;
    } t_ray_rsp;

endpackage

// ===== hw/rtl/rti_dly.sv =====
// Enabled shift-register delay line used to align side data with the datapath.
// No package dependencies.
module rti_dly #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [DATA_W-1:0] i_d,
    output logic [DATA_W-1:0] o_d
);

    logic [DATA_W-1:0] r_sr [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
            for (int s = 1; s < DEPTH; s++) begin
                r_sr[s] <= r_sr[s-1];
            end
        end
    end

    assign o_d = r_sr[DEPTH-1];

endmodule

// ===== hw/rtl/rti_wmul.sv =====
// Two-stage signed multiplier for a wide operand times a narrow one.
// Splits the wide operand into chunks; no package dependencies.
module rti_wmul #(
    parameter int A_W = 43,
    parameter int B_W = 21
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [A_W-1:0]   i_a,
    input  logic signed [B_W-1:0]   i_b,
    output logic signed [A_W+B_W-1:0] o_p
);

    localparam int CH_W = B_W;
    localparam int NCH  = (A_W + CH_W - 1) / CH_W;
    localparam int PP_W = CH_W + B_W + 1;
    localparam int P_W  = A_W + B_W;

    logic signed [NCH*CH_W-1:0] w_aext;
    logic signed [PP_W-1:0]     r_pp [NCH];
    logic signed [P_W-1:0]      w_sum;
    logic signed [P_W-1:0]      r_p;

    assign w_aext = (NCH*CH_W)'(i_a);

    for (genvar c = 0; c < NCH; c++) begin : g_chunk
        logic        [CH_W-1:0] w_ch;
        logic signed [CH_W:0]   w_op;
        assign w_ch = w_aext[c*CH_W +: CH_W];
        // top chunk carries the sign, lower chunks are unsigned
        if (c == NCH - 1) begin : g_top
            assign w_op = {w_ch[CH_W-1], w_ch};
        end else begin : g_low
            assign w_op = {1'b0, w_ch};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pp[c] <= w_op * i_b;
            end
        end
    end

    always_comb begin
        w_sum = '0;
        for (int c = 0; c < NCH; c++) begin
            w_sum = w_sum + (P_W'(r_pp[c]) <<< (c * CH_W));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= w_sum;
        end
    end

    assign o_p = r_p;

endmodule

// ===== hw/rtl/rti_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Expects num < den << QUO_W; no package dependencies.
module rti_div #(
    parameter int NUM_W = 76,
    parameter int DEN_W = 66,
    parameter int QUO_W = 20
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);

    localparam int XW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [NUM_W-1:0] r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        logic [NUM_W-1:0] w_rem_in;
        logic [DEN_W-1:0] w_den_in;
        logic [QUO_W-1:0] w_quo_in;
        logic [XW-1:0]    w_shd;
        logic [XW-1:0]    w_diff;
        logic             w_ge;

        if (s == 0) begin : g_first
            assign w_rem_in = i_num;
            assign w_den_in = i_den;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_den_in = r_den[s-1];
            assign w_quo_in = r_quo[s-1];
        end

        assign w_shd  = XW'(w_den_in) << (QUO_W - 1 - s);
        assign w_ge   = XW'(w_rem_in) >= w_shd;
        assign w_diff = XW'(w_rem_in) - w_shd;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= w_ge ? NUM_W'(w_diff) : w_rem_in;
                r_den[s] <= w_den_in;
                r_quo[s] <= w_quo_in | (w_ge ? (QUO_W'(1) << (QUO_W - 1 - s)) : '0);
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

// ===== hw/rtl/ray_triangle_intersect.sv =====
// Ray/triangle intersector: takes one ray per cycle when not stalled and tests it against
// a configured triangle with Cramer's rule, reporting hit, distance t and interpolated
// texture u/v. Depends on rti_pkg, rti_dly, rti_wmul and rti_div.
//
// One ray request can be accepted every clock cycle while the pipeline is not held.
// Six stages form the cofactors and the four 3x3 determinants, two more normalize the
// sign and check the barycentric bounds, and the texture path then runs restoring
// dividers for u and v that retire one quotient bit per stage (COORD_WIDTH + 1 stages),
// which sets the latency. Distance uses its own divider in parallel. Valid bits travel
// with the data; when the two-entry response queue is full and the last stage holds a
// result, the whole pipeline holds.
// Configure the vertices, texture coordinates and minimum distance only while no ray is
// in flight. A miss returns hit, distance, tex_u and tex_v all zero.
module ray_triangle_intersect import rti_pkg::*; #(
    parameter int FRAC_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_ray_req              i_in_req,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_ray_rsp              o_out_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // datapath widths
    localparam int CRD_W  = COORD_WIDTH;
    localparam int DIF_W  = CRD_W + 1;          // edge and ray differences
    localparam int PRD_W  = 2 * DIF_W;          // 2x2 products
    localparam int COF_W  = PRD_W + 1;          // cofactors
    localparam int MPR_W  = COF_W + DIF_W;      // cofactor times edge
    localparam int DET_W  = MPR_W + 2;          // sum of three
    localparam int SGN_W  = DET_W + 1;          // after sign normalization
    localparam int TNUM_W = DET_W + FRAC_BITS;  // distance dividend
    localparam int OVF_W  = DET_W + CRD_W + FRAC_BITS;
    localparam int XPR_W  = SGN_W + DIF_W;      // barycentric times texture delta
    localparam int XNUM_W = XPR_W + 2;          // texture dividend
    localparam int LAST   = CRD_W + 12;

    typedef logic [3*CRD_W-1:0] t_vext;
    typedef logic [2*CRD_W-1:0] t_text;

    // ---------------------------------------------------------------- configuration
    logic [VERTEX_W-1:0]   r_vtx [3];
    logic [TEXC_W-1:0]     r_tex [3];
    logic [MIN_DIST_W-1:0] r_min_dist;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < 3; n++) begin
                r_vtx[n] <= '0;
                r_tex[n] <= '0;
            end
            r_min_dist <= MIN_DIST_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VERTEX_ONE:   r_vtx[0]   <= i_cfg_data[VERTEX_W-1:0];
                CFG_VERTEX_TWO:   r_vtx[1]   <= i_cfg_data[VERTEX_W-1:0];
                CFG_VERTEX_THREE: r_vtx[2]   <= i_cfg_data[VERTEX_W-1:0];
                CFG_TEXC_ONE:     r_tex[0]   <= i_cfg_data[TEXC_W-1:0];
                CFG_TEXC_TWO:     r_tex[1]   <= i_cfg_data[TEXC_W-1:0];
                CFG_TEXC_THREE:   r_tex[2]   <= i_cfg_data[TEXC_W-1:0];
                CFG_MIN_DIST:     r_min_dist <= i_cfg_data[MIN_DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // Unpack vertex and texture fields; bits past the register read as zero.
    t_vext                     w_vx [3];
    t_text                     w_tx [3];
    logic signed [CRD_W-1:0]   w_p  [3][3];
    logic signed [CRD_W-1:0]   w_tu [3];
    logic signed [CRD_W-1:0]   w_tv [3];

    for (genvar n = 0; n < 3; n++) begin : g_fld
        assign w_vx[n] = t_vext'(r_vtx[n]);
        assign w_tx[n] = t_text'(r_tex[n]);
        for (genvar q = 0; q < 3; q++) begin : g_axis
            assign w_p[n][q] = w_vx[n][q*CRD_W +: CRD_W];
        end
        assign w_tu[n] = w_tx[n][0 +: CRD_W];
        assign w_tv[n] = w_tx[n][CRD_W +: CRD_W];
    end

    // Triangle edges and texture deltas are static while rays are in flight.
    logic signed [DIF_W-1:0] w_a, w_b, w_c, w_d, w_e, w_f;
    logic signed [DIF_W-1:0] w_d1u, w_d2u, w_d1v, w_d2v;
    logic        [CRD_W-1:0] w_min;

    assign w_a   = DIF_W'(w_p[0][0]) - DIF_W'(w_p[1][0]);
    assign w_b   = DIF_W'(w_p[0][1]) - DIF_W'(w_p[1][1]);
    assign w_c   = DIF_W'(w_p[0][2]) - DIF_W'(w_p[1][2]);
    assign w_d   = DIF_W'(w_p[0][0]) - DIF_W'(w_p[2][0]);
    assign w_e   = DIF_W'(w_p[0][1]) - DIF_W'(w_p[2][1]);
    assign w_f   = DIF_W'(w_p[0][2]) - DIF_W'(w_p[2][2]);
    assign w_d1u = DIF_W'(w_tu[1]) - DIF_W'(w_tu[0]);
    assign w_d2u = DIF_W'(w_tu[2]) - DIF_W'(w_tu[0]);
    assign w_d1v = DIF_W'(w_tv[1]) - DIF_W'(w_tv[0]);
    assign w_d2v = DIF_W'(w_tv[2]) - DIF_W'(w_tv[0]);
    assign w_min = CRD_W'(r_min_dist);

    // ---------------------------------------------------------------- flow control
    logic       w_en;
    logic       w_push;
    logic       w_pop;
    logic [LAST:1] r_vld;
    logic [1:0] r_cnt;

    // Advance unless a finished result sits in the last stage with the queue full.
    assign w_en       = !r_vld[LAST] || (r_cnt != 2'd2);
    assign o_in_ready = w_en;
    assign w_push     = w_en && r_vld[LAST];
    assign w_pop      = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST-1:1], i_in_valid};
        end
    end

    // ---------------------------------------------------------------- stage 1: ray terms
    logic signed [DIF_W-1:0] r1_g, r1_h, r1_i, r1_j, r1_k, r1_l;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_g <= DIF_W'(i_in_req.dir_x);
            r1_h <= DIF_W'(i_in_req.dir_y);
            r1_i <= DIF_W'(i_in_req.dir_z);
            r1_j <= DIF_W'(w_p[0][0]) - DIF_W'(i_in_req.origin_x);
            r1_k <= DIF_W'(w_p[0][1]) - DIF_W'(i_in_req.origin_y);
            r1_l <= DIF_W'(w_p[0][2]) - DIF_W'(i_in_req.origin_z);
        end
    end

    // ---------------------------------------------------------------- stage 2: 2x2 products
    logic signed [PRD_W-1:0] r2_ei, r2_hf, r2_gf, r2_di, r2_dh, r2_eg;
    logic signed [PRD_W-1:0] r2_ak, r2_jb, r2_jc, r2_al, r2_bl, r2_kc;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_ei <= w_e * r1_i;
            r2_hf <= r1_h * w_f;
            r2_gf <= r1_g * w_f;
            r2_di <= w_d * r1_i;
            r2_dh <= w_d * r1_h;
            r2_eg <= w_e * r1_g;
            r2_ak <= w_a * r1_k;
            r2_jb <= r1_j * w_b;
            r2_jc <= r1_j * w_c;
            r2_al <= w_a * r1_l;
            r2_bl <= w_b * r1_l;
            r2_kc <= r1_k * w_c;
        end
    end

    // ---------------------------------------------------------------- stage 3: cofactors
    logic signed [COF_W-1:0] r3_ei_hf, r3_gf_di, r3_dh_eg, r3_ak_jb, r3_jc_al, r3_bl_kc;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_ei_hf <= COF_W'(r2_ei) - COF_W'(r2_hf);
            r3_gf_di <= COF_W'(r2_gf) - COF_W'(r2_di);
            r3_dh_eg <= COF_W'(r2_dh) - COF_W'(r2_eg);
            r3_ak_jb <= COF_W'(r2_ak) - COF_W'(r2_jb);
            r3_jc_al <= COF_W'(r2_jc) - COF_W'(r2_al);
            r3_bl_kc <= COF_W'(r2_bl) - COF_W'(r2_kc);
        end
    end

    // carry ray terms alongside to stage 3
    logic [6*DIF_W-1:0]      w_ray3;
    logic signed [DIF_W-1:0] w3_g, w3_h, w3_i, w3_j, w3_k, w3_l;

    rti_dly #(.DATA_W(6*DIF_W), .DEPTH(2)) u_ray_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({r1_g, r1_h, r1_i, r1_j, r1_k, r1_l}),
        .o_d   (w_ray3)
    );

    assign w3_g = w_ray3[5*DIF_W +: DIF_W];
    assign w3_h = w_ray3[4*DIF_W +: DIF_W];
    assign w3_i = w_ray3[3*DIF_W +: DIF_W];
    assign w3_j = w_ray3[2*DIF_W +: DIF_W];
    assign w3_k = w_ray3[1*DIF_W +: DIF_W];
    assign w3_l = w_ray3[0 +: DIF_W];

    // ---------------------------------------------------------------- stages 4-5: determinants
    logic signed [COF_W-1:0] w_cof [12];
    logic signed [DIF_W-1:0] w_nar [12];
    logic signed [MPR_W-1:0] w_mp  [12];

    // determinant: a, b, c against the direction cofactors
    assign w_cof[0]  = r3_ei_hf;  assign w_nar[0]  = w_a;
    assign w_cof[1]  = r3_gf_di;  assign w_nar[1]  = w_b;
    assign w_cof[2]  = r3_dh_eg;  assign w_nar[2]  = w_c;
    // beta numerator
    assign w_cof[3]  = r3_ei_hf;  assign w_nar[3]  = w3_j;
    assign w_cof[4]  = r3_gf_di;  assign w_nar[4]  = w3_k;
    assign w_cof[5]  = r3_dh_eg;  assign w_nar[5]  = w3_l;
    // gamma numerator
    assign w_cof[6]  = r3_ak_jb;  assign w_nar[6]  = w3_i;
    assign w_cof[7]  = r3_jc_al;  assign w_nar[7]  = w3_h;
    assign w_cof[8]  = r3_bl_kc;  assign w_nar[8]  = w3_g;
    // t numerator
    assign w_cof[9]  = r3_ak_jb;  assign w_nar[9]  = w_f;
    assign w_cof[10] = r3_jc_al;  assign w_nar[10] = w_e;
    assign w_cof[11] = r3_bl_kc;  assign w_nar[11] = w_d;

    for (genvar m = 0; m < 12; m++) begin : g_det_mul
        rti_wmul #(.A_W(COF_W), .B_W(DIF_W)) u_mul (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (w_cof[m]),
            .i_b   (w_nar[m]),
            .o_p   (w_mp[m])
        );
    end

    // ---------------------------------------------------------------- stage 6: sums
    logic signed [DET_W-1:0] r6_m, r6_nb, r6_ng, r6_nt;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_m  <= DET_W'(w_mp[0]) + DET_W'(w_mp[1])  + DET_W'(w_mp[2]);
            r6_nb <= DET_W'(w_mp[3]) + DET_W'(w_mp[4])  + DET_W'(w_mp[5]);
            r6_ng <= DET_W'(w_mp[6]) + DET_W'(w_mp[7])  + DET_W'(w_mp[8]);
            r6_nt <= DET_W'(w_mp[9]) + DET_W'(w_mp[10]) + DET_W'(w_mp[11]);
        end
    end

    // ---------------------------------------------------------------- stage 7: make det positive
    logic signed [SGN_W-1:0] r7_m, r7_nb, r7_ng, r7_nt;
    logic                    r7_mzero;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_mzero <= (r6_m == '0);
            if (r6_m[DET_W-1]) begin
                r7_m  <= -SGN_W'(r6_m);
                r7_nb <= -SGN_W'(r6_nb);
                r7_ng <= -SGN_W'(r6_ng);
                r7_nt <= -SGN_W'(r6_nt);
            end else begin
                r7_m  <= SGN_W'(r6_m);
                r7_nb <= SGN_W'(r6_nb);
                r7_ng <= SGN_W'(r6_ng);
                r7_nt <= SGN_W'(r6_nt);
            end
        end
    end

    // ---------------------------------------------------------------- stage 8: bounds check
    logic signed [SGN_W:0] w_bg_sum;
    logic                  w_t_neg;
    logic                  r8_miss;
    logic [DET_W-1:0]      r8_m, r8_nb, r8_ng, r8_tn;

    assign w_bg_sum = (SGN_W+1)'(r7_nb) + (SGN_W+1)'(r7_ng);
    // t is negative when the t numerator is strictly positive
    assign w_t_neg  = !r7_nt[SGN_W-1] && (r7_nt != '0);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_miss <= r7_mzero || r7_nb[SGN_W-1] || r7_ng[SGN_W-1] || w_t_neg
                       || ((SGN_W+1)'(r7_m) < w_bg_sum);
            r8_m    <= DET_W'(r7_m);
            r8_nb   <= DET_W'(r7_nb);
            r8_ng   <= DET_W'(r7_ng);
            r8_tn   <= DET_W'(-r7_nt);
        end
    end

    // ---------------------------------------------------------------- distance path
    logic              r9_ovf;
    logic [TNUM_W-1:0] r9_num;
    logic [DET_W-1:0]  r9_m;
    logic [CRD_W-1:0]  w_qt_raw;
    logic [CRD_W-1:0]  w_qt;
    logic              w_ovf;
    logic              w_miss;

    // flag quotients that do not fit; they saturate at the output
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_ovf <= (OVF_W'(r8_tn) << FRAC_BITS) >= (OVF_W'(r8_m) << CRD_W);
            r9_num <= TNUM_W'(r8_tn) << FRAC_BITS;
            r9_m   <= r8_m;
        end
    end

    rti_div #(.NUM_W(TNUM_W), .DEN_W(DET_W), .QUO_W(CRD_W)) u_t_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r9_num),
        .i_den (r9_m),
        .o_quo (w_qt_raw)
    );

    rti_dly #(.DATA_W(CRD_W), .DEPTH(3)) u_qt_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (w_qt_raw),
        .o_d   (w_qt)
    );

    rti_dly #(.DATA_W(1), .DEPTH(LAST-9)) u_ovf_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r9_ovf),
        .o_d   (w_ovf)
    );

    rti_dly #(.DATA_W(1), .DEPTH(LAST-8)) u_miss_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r8_miss),
        .o_d   (w_miss)
    );

    // ---------------------------------------------------------------- texture path
    // tex = t0 + floor((nb*d1 + ng*d2) / m); the dividend is biased by m << CRD_W so it
    // stays positive, and the bias drops out modulo 2^CRD_W.
    logic signed [SGN_W-1:0] w_nbs, w_ngs;
    logic signed [XPR_W-1:0] w_xp [4];
    logic [DET_W-1:0]        w_m10;
    logic [XNUM_W-1:0]       r11_yu, r11_yv;
    logic [DET_W-1:0]        r11_m;
    logic [CRD_W:0]          w_qu, w_qv;

    assign w_nbs = {1'b0, r8_nb};
    assign w_ngs = {1'b0, r8_ng};

    rti_wmul #(.A_W(SGN_W), .B_W(DIF_W)) u_mul_nbu (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_nbs), .i_b (w_d1u), .o_p (w_xp[0])
    );
    rti_wmul #(.A_W(SGN_W), .B_W(DIF_W)) u_mul_ngu (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_ngs), .i_b (w_d2u), .o_p (w_xp[1])
    );
    rti_wmul #(.A_W(SGN_W), .B_W(DIF_W)) u_mul_nbv (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_nbs), .i_b (w_d1v), .o_p (w_xp[2])
    );
    rti_wmul #(.A_W(SGN_W), .B_W(DIF_W)) u_mul_ngv (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_ngs), .i_b (w_d2v), .o_p (w_xp[3])
    );

    rti_dly #(.DATA_W(DET_W), .DEPTH(2)) u_m_dly (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r8_m),
        .o_d   (w_m10)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r11_yu <= XNUM_W'(w_xp[0]) + XNUM_W'(w_xp[1]) + (XNUM_W'(w_m10) << CRD_W);
            r11_yv <= XNUM_W'(w_xp[2]) + XNUM_W'(w_xp[3]) + (XNUM_W'(w_m10) << CRD_W);
            r11_m  <= w_m10;
        end
    end

    rti_div #(.NUM_W(XNUM_W), .DEN_W(DET_W), .QUO_W(CRD_W+1)) u_u_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r11_yu),
        .i_den (r11_m),
        .o_quo (w_qu)
    );

    rti_div #(.NUM_W(XNUM_W), .DEN_W(DET_W), .QUO_W(CRD_W+1)) u_v_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r11_yv),
        .i_den (r11_m),
        .o_quo (w_qv)
    );

    // ---------------------------------------------------------------- result and queue
    t_ray_rsp w_rsp;
    logic     w_hit;

    assign w_hit = !w_miss && (w_ovf || (w_qt >= w_min));

    always_comb begin
        w_rsp = '0;
        if (w_hit) begin
            w_rsp.hit      = 1'b1;
            w_rsp.distance = w_ovf ? '1 : w_qt;
            w_rsp.tex_u    = w_tu[0] + w_qu[CRD_W-1:0];
            w_rsp.tex_v    = w_tv[0] + w_qv[CRD_W-1:0];
        end
    end

    t_ray_rsp r_q [2];
    logic     r_wp;
    logic     r_rp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_rsp;
        end
    end

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_rsp   = r_q[r_rp];

`ifndef SYNTHESIS
    ap_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("response queue count out of range");

    ap_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    ap_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_rsp.hit) |->
        (o_out_rsp.distance == '0 && o_out_rsp.tex_u == '0 && o_out_rsp.tex_v == '0))
        else $error("miss response carries a nonzero payload");
`endif

endmodule

// ===== tb/tb_ray_triangle_intersect.sv =====
// Self-checking testbench for ray_triangle_intersect: directed and random rays against
// configured triangles, with an exact-integer intersection predictor and a response scoreboard.
// Depends on rti_pkg and the ray_triangle_intersect RTL.
module tb_ray_triangle_intersect;
    import rti_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [159:0] wide_t;

    localparam int LATENCY_WAIT = 48;    // pipeline depth plus margin
    localparam int STALL_LIMIT  = 3000;  // cycles with no handshake at all
    localparam int LONG_HOLD    = 300;
    localparam int ONE          = 1 << 10;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  ray_valid = 1'b0;
    t_ray_req              ray_req = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  rsp_ready = 1'b0;
    t_ray_rsp              o_out_rsp;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_VERTEX_ONE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Mirror of the triangle registers, updated with every write.
    logic [VERTEX_W-1:0]   vertex_reg [3];
    logic [TEXC_W-1:0]     texc_reg [3];
    logic [MIN_DIST_W-1:0] min_dist_reg;

    t_ray_rsp expected_rsp [$];
    int  mismatches = 0;
    int  rays_sent = 0;
    int  rsp_seen = 0;
    int  hits_seen = 0;
    int  idle_cycles = 0;
    bit  tx_idle_en = 1'b0;
    bit  rx_idle_en = 1'b0;
    int  long_hold_req = 0;
    int  hold_left = 0;

    ray_triangle_intersect uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (ray_valid),
        .o_in_ready (o_in_ready),
        .i_in_req   (ray_req),
        .o_out_valid(o_out_valid),
        .i_out_ready(rsp_ready),
        .o_out_rsp  (o_out_rsp),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------------------
    // Intersection predictor
    // ---------------------------------------------------------------------------------

    // Floor division for a positive divisor; SV division truncates toward zero.
    function automatic wide_t div_floor(wide_t num, wide_t den);
        wide_t q;
        q = num / den;
        if (num < 0 && (num % den) != 0) q = q - 1;
        return q;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] sat_signed(wide_t v);
        wide_t hi, lo;
        hi = (1 <<< (COORD_WIDTH - 1)) - 1;
        lo = -(1 <<< (COORD_WIDTH - 1));
        if (v < lo) return lo[COORD_WIDTH-1:0];
        if (v > hi) return hi[COORD_WIDTH-1:0];
        return v[COORD_WIDTH-1:0];
    endfunction

    function automatic t_ray_rsp predict_intersection(t_ray_req r);
        wide_t px [3];
        wide_t py [3];
        wide_t pz [3];
        wide_t ea, eb, ec, ed, ee, ef, dx, dy, dz, sx, sy, sz;
        wide_t c_ei, c_gf, c_dh, c_ak, c_jc, c_bl;
        wide_t det, num_beta, num_gamma, num_t, t_q, t0, t1, t2, tq_tex [2];
        wide_t dist_max;
        t_ray_rsp rsp;
        rsp = '0;
        for (int n = 0; n < 3; n++) begin
            px[n] = $signed(vertex_reg[n][COORD_WIDTH-1:0]);
            py[n] = $signed(vertex_reg[n][2*COORD_WIDTH-1:COORD_WIDTH]);
            pz[n] = $signed(vertex_reg[n][3*COORD_WIDTH-1:2*COORD_WIDTH]);
        end
        ea = px[0] - px[1]; eb = py[0] - py[1]; ec = pz[0] - pz[1];
        ed = px[0] - px[2]; ee = py[0] - py[2]; ef = pz[0] - pz[2];
        dx = wide_t'(r.dir_x); dy = wide_t'(r.dir_y); dz = wide_t'(r.dir_z);
        sx = px[0] - wide_t'(r.origin_x);
        sy = py[0] - wide_t'(r.origin_y);
        sz = pz[0] - wide_t'(r.origin_z);

        c_ei = ee * dz - dy * ef;
        c_gf = dx * ef - ed * dz;
        c_dh = ed * dy - ee * dx;
        c_ak = ea * sy - sx * eb;
        c_jc = sx * ec - ea * sz;
        c_bl = eb * sz - sy * ec;

        det       = ea * c_ei + eb * c_gf + ec * c_dh;
        num_beta  = sx * c_ei + sy * c_gf + sz * c_dh;
        num_gamma = dz * c_ak + dy * c_jc + dx * c_bl;
        num_t     = ef * c_ak + ee * c_jc + ed * c_bl;

        // Degenerate triangle or ray parallel to its plane
        if (det == 0) return rsp;
        if (det < 0) begin
            det = -det; num_beta = -num_beta; num_gamma = -num_gamma; num_t = -num_t;
        end
        if (num_beta < 0 || num_gamma < 0 || det < num_beta + num_gamma) return rsp;
        t_q = div_floor(-num_t * ONE, det);
        if (t_q < wide_t'({1'b0, min_dist_reg})) return rsp;

        for (int n = 0; n < 2; n++) begin
            t0 = $signed(texc_reg[0][n*COORD_WIDTH +: COORD_WIDTH]);
            t1 = $signed(texc_reg[1][n*COORD_WIDTH +: COORD_WIDTH]);
            t2 = $signed(texc_reg[2][n*COORD_WIDTH +: COORD_WIDTH]);
            tq_tex[n] = div_floor(det * t0 + num_beta * (t1 - t0) + num_gamma * (t2 - t0), det);
        end
        dist_max = (1 <<< COORD_WIDTH) - 1;
        rsp.hit = 1'b1;
        if (t_q > dist_max) rsp.distance = dist_max[COORD_WIDTH-1:0];
        else rsp.distance = t_q[COORD_WIDTH-1:0];
        rsp.tex_u = sat_signed(tq_tex[0]);
        rsp.tex_v = sat_signed(tq_tex[1]);
        return rsp;
    endfunction

    // ---------------------------------------------------------------------------------
    // Scoreboard: predict on request acceptance, compare on response acceptance
    // ---------------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_ray_rsp exp_rsp;
        if (i_rst_n && ray_valid && o_in_ready) begin
            expected_rsp.push_back(predict_intersection(ray_req));
            rays_sent++;
        end
        if (i_rst_n && o_out_valid && rsp_ready) begin
            rsp_seen++;
            if (expected_rsp.size() == 0) begin
                $error("response with nothing expected: hit=%0d distance=%0d",
                       o_out_rsp.hit, o_out_rsp.distance);
                mismatches++;
            end else begin
                exp_rsp = expected_rsp.pop_front();
                if (o_out_rsp.hit) hits_seen++;
                if (o_out_rsp.hit !== exp_rsp.hit) begin
                    $error("hit: expected %0d, actual %0d", exp_rsp.hit, o_out_rsp.hit);
                    mismatches++;
                end
                if (o_out_rsp.distance !== exp_rsp.distance) begin
                    $error("distance: expected %0d, actual %0d",
                           exp_rsp.distance, o_out_rsp.distance);
                    mismatches++;
                end
                if (o_out_rsp.tex_u !== exp_rsp.tex_u) begin
                    $error("tex_u: expected %0d, actual %0d", exp_rsp.tex_u, o_out_rsp.tex_u);
                    mismatches++;
                end
                if (o_out_rsp.tex_v !== exp_rsp.tex_v) begin
                    $error("tex_v: expected %0d, actual %0d", exp_rsp.tex_v, o_out_rsp.tex_v);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: count cycles where neither channel completes a handshake.
    always @(posedge i_clk) begin
        if ((ray_valid && o_in_ready) || (o_out_valid && rsp_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[ray_triangle_intersect] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Response side: random short stalls, plus one long hold on request.
    always @(negedge i_clk) begin
        if (hold_left == 0 && long_hold_req > 0) begin
            hold_left = long_hold_req;
            long_hold_req = 0;
        end else if (hold_left == 0 && rx_idle_en && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(1, 4);
        end
        if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
        end else begin
            rsp_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------------------
    // Shared driving tasks
    // ---------------------------------------------------------------------------------

    // Offer one ray; leave valid high afterwards so back-to-back requests stream.
    task automatic send_ray(input t_ray_req r);
        int gap;
        if (tx_idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            ray_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        ray_valid <= 1'b1;
        ray_req   <= r;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_fields(input logic signed [COORD_WIDTH-1:0] ox, oy, oz, dx, dy, dz);
        t_ray_req r;
        r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
        r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
        send_ray(r);
    endtask

    // Drop valid, wait for every response, then let the pipeline settle.
    task automatic drain_pipeline();
        @(negedge i_clk);
        ray_valid <= 1'b0;
        while (expected_rsp.size() != 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_VERTEX_ONE:   vertex_reg[0] = data[VERTEX_W-1:0];
            CFG_VERTEX_TWO:   vertex_reg[1] = data[VERTEX_W-1:0];
            CFG_VERTEX_THREE: vertex_reg[2] = data[VERTEX_W-1:0];
            CFG_TEXC_ONE:     texc_reg[0] = data[TEXC_W-1:0];
            CFG_TEXC_TWO:     texc_reg[1] = data[TEXC_W-1:0];
            CFG_TEXC_THREE:   texc_reg[2] = data[TEXC_W-1:0];
            CFG_MIN_DIST:     min_dist_reg = data[MIN_DIST_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pack_vertex(input int x, y, z);
        logic [COORD_WIDTH-1:0] fx, fy, fz;
        fx = x; fy = y; fz = z;
        return CFG_DATA_W'({fz, fy, fx});
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pack_texc(input int u, v);
        logic [COORD_WIDTH-1:0] fu, fv;
        fu = u; fv = v;
        return CFG_DATA_W'({fv, fu});
    endfunction

    // Write all seven registers with the given triangle.
    task automatic load_triangle(input int v [9], input int tc [6], input int min_d);
        cfg_write(CFG_VERTEX_ONE,   pack_vertex(v[0], v[1], v[2]));
        cfg_write(CFG_VERTEX_TWO,   pack_vertex(v[3], v[4], v[5]));
        cfg_write(CFG_VERTEX_THREE, pack_vertex(v[6], v[7], v[8]));
        cfg_write(CFG_TEXC_ONE,     pack_texc(tc[0], tc[1]));
        cfg_write(CFG_TEXC_TWO,     pack_texc(tc[2], tc[3]));
        cfg_write(CFG_TEXC_THREE,   pack_texc(tc[4], tc[5]));
        cfg_write(CFG_MIN_DIST,     CFG_DATA_W'(min_d));
    endtask

    function automatic int rand_coord(input int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // Random triangle; span picks the vertex spread, sometimes the full range.
    task automatic load_random_triangle();
        int v [9];
        int tc [6];
        int span, min_d;
        span = ($urandom_range(0, 4) == 0) ? 524287 : (1 << $urandom_range(10, 17));
        foreach (v[n]) v[n] = rand_coord(span);
        foreach (tc[n]) tc[n] = ($urandom_range(0, 3) == 0) ? rand_coord(524287)
                                                               : rand_coord(1 << 14);
        case ($urandom_range(0, 4))
            0: min_d = 0;
            1: min_d = 1048575;
            2: min_d = $urandom_range(0, 1048575);
            default: min_d = $urandom_range(0, 4 * ONE);
        endcase
        load_triangle(v, tc, min_d);
    endtask

    // Aim a ray at a random point inside the current triangle from a random distance.
    function automatic t_ray_req aimed_ray();
        longint p [3][3];
        longint tgt [3];
        longint dir [3];
        int bb, gg, s;
        t_ray_req r;
        for (int n = 0; n < 3; n++)
            for (int q = 0; q < 3; q++)
                p[n][q] = $signed(vertex_reg[n][q*COORD_WIDTH +: COORD_WIDTH]);
        bb = $urandom_range(0, 256);
        gg = $urandom_range(0, 256 - bb);
        s  = $urandom_range(1, 16);
        if ($urandom_range(0, 9) == 0) s = -s;   // target behind the origin
        for (int q = 0; q < 3; q++) begin
            tgt[q] = p[0][q] + ((p[1][q] - p[0][q]) * bb + (p[2][q] - p[0][q]) * gg) / 256;
            dir[q] = rand_coord(1 << $urandom_range(4, 14));
        end
        r.dir_x = dir[0]; r.dir_y = dir[1]; r.dir_z = dir[2];
        r.origin_x = tgt[0] - dir[0] * s;
        r.origin_y = tgt[1] - dir[1] * s;
        r.origin_z = tgt[2] - dir[2] * s;
        return r;
    endfunction

    function automatic t_ray_req noise_ray();
        t_ray_req r;
        r = {$urandom, $urandom, $urandom, $urandom};
        return r;
    endfunction

    // Mostly aimed rays, the rest arbitrary bit patterns.
    task automatic send_random_rays(input int count);
        repeat (count) begin
            if ($urandom_range(0, 9) < 7) send_ray(aimed_ray());
            else send_ray(noise_ray());
        end
    endtask

    // ---------------------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------------------

    // Reset state is an all-zero triangle: every ray must miss.
    task automatic test_reset_triangle();
        send_fields(0, 0, 0, ONE, ONE, ONE);
        send_fields(524287, -524288, 1, -1, 524287, -524288);
        drain_pipeline();
    endtask

    // Axis-aligned triangle at z = 8: interior, vertex, edge, outside, parallel, behind.
    task automatic test_basic_geometry();
        int v [9] = '{0, 0, 8 * ONE, 4 * ONE, 0, 8 * ONE, 0, 4 * ONE, 8 * ONE};
        int tc [6] = '{0, 0, 2 * ONE, -ONE, 3 * ONE, 5 * ONE};
        load_triangle(v, tc, 1);
        send_fields(ONE, ONE, 0, 0, 0, ONE);              // interior hit, t = 8
        send_fields(0, 0, 0, 0, 0, ONE);                  // on the first vertex
        send_fields(2 * ONE, 2 * ONE, 0, 0, 0, 2 * ONE);  // on the far edge, beta+gamma = 1
        send_fields(-ONE, ONE, 0, 0, 0, ONE);             // beta negative
        send_fields(3 * ONE, 3 * ONE, 0, 0, 0, ONE);      // beta+gamma above one
        send_fields(ONE, ONE, 0, ONE, 0, 0);              // parallel to the plane
        send_fields(ONE, ONE, 0, 0, 0, -ONE);             // triangle behind the origin
        send_fields(ONE, 3, 0, 7, -5, 3);                 // oblique ray, inexact quotients
        drain_pipeline();
    endtask

    // Distance threshold at, just above, and at the extremes.
    task automatic test_min_distance();
        int v [9] = '{0, 0, 8 * ONE, 4 * ONE, 0, 8 * ONE, 0, 4 * ONE, 8 * ONE};
        int tc [6] = '{ONE, ONE, ONE, ONE, ONE, ONE};
        load_triangle(v, tc, 8 * ONE);
        send_fields(ONE, ONE, 0, 0, 0, ONE);
        drain_pipeline();
        cfg_write(CFG_MIN_DIST, CFG_DATA_W'(8 * ONE + 1));
        send_fields(ONE, ONE, 0, 0, 0, ONE);
        drain_pipeline();
        cfg_write(CFG_MIN_DIST, '0);
        send_fields(ONE, ONE, 8 * ONE, 0, 0, ONE);        // origin in the plane, t = 0
        drain_pipeline();
        cfg_write(CFG_MIN_DIST, CFG_DATA_W'(1048575));
        send_fields(ONE, ONE, -524288, 0, 0, 1);          // huge t, saturates
        drain_pipeline();
    endtask

    // Extreme field values, texture coordinates at their range limits.
    task automatic test_extremes();
        int v [9] = '{-524288, -524288, 524287, 524287, -524288, 524287, -524288, 524287, -524288};
        int tc [6] = '{524287, -524288, -524288, 524287, 524287, 524287};
        load_triangle(v, tc, 0);
        send_fields(524287, 524287, 524287, 524287, 524287, 524287);
        send_fields(-524288, -524288, -524288, -524288, -524288, -524288);
        send_fields(0, 0, 0, 0, 0, 0);
        send_fields(0, 0, -524288, 0, 0, 1);
        send_fields(-1, -1, -1, -524288, 1, 524287);
        send_fields(0, 0, 0, 1, 1, 1);
        drain_pipeline();
    endtask

    // Hold responses off for a long stretch while rays keep coming.
    task automatic test_back_pressure();
        load_random_triangle();
        @(posedge i_clk);
        long_hold_req = LONG_HOLD;
        send_random_rays(120);
        drain_pipeline();
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        repeat (phases) begin
            load_random_triangle();
            send_random_rays(per_phase);
            drain_pipeline();
        end
    endtask

    initial begin
        for (int n = 0; n < 3; n++) begin
            vertex_reg[n] = '0;
            texc_reg[n] = '0;
        end
        min_dist_reg = 1;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_triangle();
        test_basic_geometry();
        test_min_distance();
        test_extremes();

        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        test_back_pressure();
        test_random_phases(14, 110);

        // Last stretch runs at full rate on both sides.
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_phases(2, 90);

        $display("Covered %0d rays over %0d responses, %0d hits, random triangles and thresholds,",
                 rays_sent, rsp_seen, hits_seen);
        $display("random stalls on both sides and one long output hold.");
        if (mismatches == 0 && expected_rsp.size() == 0) begin
            $display("[ray_triangle_intersect] OK");
        end else begin
            $display("[ray_triangle_intersect] ERROR");
        end
        $finish;
    end

endmodule
